FILE: design/wsst_pkg.sv
`default_nettype none

package wsst_pkg;

  localparam int VALUE_W     = 16;
  localparam int TICK_W      = 17;
  localparam int CNT_OUT_W   = 10;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [TICK_W-1:0] WINDOW_RESET = 17'd60000;

  // Codes of the operation input field.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  typedef enum logic {
    CMD_SAMPLE,
    CMD_TICK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                  kind;
    logic                       ch;
    logic signed [VALUE_W-1:0]  value;
  } cmd_t;

endpackage

`default_nettype wire

FILE: design/wsst_front.sv
`default_nettype none

module wsst_front #(
  parameter int NUM_CHANNELS = 2
) (
  input  wire logic                                in_valid,
  output      logic                                in_stall,
  input  wire logic                                operation,
  input  wire logic                                channel,
  input  wire logic signed [wsst_pkg::VALUE_W-1:0] value,
  input  wire logic                                sample_valid,
  input  wire logic                                q_full,
  output      logic                                q_push,
  output      wsst_pkg::cmd_t                      q_cmd
);
  import wsst_pkg::*;

  logic keep;
  logic ch_ok;

  // Invalid samples and samples to channels that do not exist have no effect,
  // so they are dropped here and never reach the queue.
  assign ch_ok    = 32'(channel) < NUM_CHANNELS;
  assign keep     = (operation == OP_TICK) || (sample_valid && ch_ok);
  assign in_stall = q_full;
  assign q_push   = in_valid && !in_stall && keep;

  always_comb begin
    q_cmd.kind  = (operation == OP_TICK) ? CMD_TICK : CMD_SAMPLE;
    q_cmd.ch    = channel;
    q_cmd.value = value;
  end

endmodule

`default_nettype wire

FILE: design/wsst_fifo.sv
`default_nettype none

module wsst_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire wsst_pkg::cmd_t push_cmd,
  input  wire logic           pop,
  output      wsst_pkg::cmd_t pop_cmd,
  output      logic           full,
  output      logic           empty
);
  import wsst_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full    = count == QCNT_W'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/wsst_div.sv
`default_nettype none

module wsst_div #(
  parameter int DVD_W = 26,
  parameter int DVS_W = 10
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic signed [DVD_W-1:0] dividend,
  input  wire logic        [DVS_W-1:0] divisor,
  output      logic                    done,
  output      logic signed [DVD_W-1:0] quotient
);

  localparam int STEP_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic              busy;
  logic [STEP_W-1:0] step;
  logic              neg;
  logic [DVD_W-1:0]  q;
  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  dvs;
  logic [DVD_W-1:0]  mag;
  logic [DVS_W:0]    shifted;
  logic [DVS_W:0]    trial;

  // Restoring division on magnitudes, one quotient bit per cycle; the sign
  // is applied at the end, which gives truncation toward zero.
  assign mag      = dividend[DVD_W-1] ? (~dividend + 1'b1) : dividend;
  assign shifted  = {rem, q[DVD_W-1]};
  assign trial    = shifted - {1'b0, dvs};
  assign quotient = neg ? $signed(~q + 1'b1) : $signed(q);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == STEP_W'(DVD_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[DVD_W-1];
      q   <= mag;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[DVS_W]) begin
        rem <= trial[DVS_W-1:0];
        q   <= {q[DVD_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DVS_W-1:0];
        q   <= {q[DVD_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/wsst_back.sv
`default_nettype none

module wsst_back #(
  parameter int NUM_CHANNELS = 2,
  parameter int MAX_COUNT    = 1023
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_write,
  input  wire logic [wsst_pkg::TICK_W-1:0]           cfg_data,
  input  wire logic                                  q_empty,
  input  wire wsst_pkg::cmd_t                        q_cmd,
  output      logic                                  q_pop,
  output      logic                                  out_valid,
  input  wire logic                                  out_stall,
  output      logic                                  out_channel,
  output      logic signed [wsst_pkg::VALUE_W-1:0]   average,
  output      logic signed [wsst_pkg::VALUE_W-1:0]   minimum,
  output      logic signed [wsst_pkg::VALUE_W-1:0]   maximum,
  output      logic [wsst_pkg::CNT_OUT_W-1:0]        sample_count,
  output      logic                                  last
);
  import wsst_pkg::*;

  localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CW    = $clog2(MAX_COUNT + 1);
  localparam int SUM_W = VALUE_W + CW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DIV
  } state_t;

  state_t                   state;
  logic [TICK_W-1:0]        window_ticks;
  logic [TICK_W-1:0]        tick_counter;
  logic [TICK_W-1:0]        tick_next;
  logic [CH_W-1:0]          scan;
  logic [CH_W-1:0]          rd_idx;
  logic                     scan_end;
  logic                     more_after;
  logic                     out_free;
  logic                     emit;

  logic signed [SUM_W-1:0]   running_sum [NUM_CHANNELS];
  logic signed [VALUE_W-1:0] running_min [NUM_CHANNELS];
  logic signed [VALUE_W-1:0] running_max [NUM_CHANNELS];
  logic [CW-1:0]             chan_count  [NUM_CHANNELS];

  logic signed [SUM_W-1:0]   cur_sum;
  logic signed [VALUE_W-1:0] cur_min;
  logic signed [VALUE_W-1:0] cur_max;
  logic [CW-1:0]             cur_cnt;
  logic signed [SUM_W-1:0]   val_ext;

  logic                      div_start;
  logic                      div_done;
  logic signed [SUM_W-1:0]   div_quot;

  assign rd_idx    = (state == ST_IDLE) ? CH_W'(q_cmd.ch) : scan;
  assign cur_sum   = running_sum[rd_idx];
  assign cur_min   = running_min[rd_idx];
  assign cur_max   = running_max[rd_idx];
  assign cur_cnt   = chan_count[rd_idx];
  assign val_ext   = SUM_W'(q_cmd.value);
  assign tick_next = tick_counter + 1'b1;
  assign scan_end  = scan == CH_W'(NUM_CHANNELS - 1);
  assign out_free  = !out_valid || !out_stall;
  assign emit      = (state == ST_DIV) && div_done && out_free;
  assign q_pop     = (state == ST_IDLE) && !q_empty;
  assign div_start = (state == ST_SCAN) && (cur_cnt != '0);

  // The record being emitted is the last one unless a higher channel still
  // holds samples.
  always_comb begin
    more_after = 1'b0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      more_after = more_after || ((CH_W'(i) > scan) && (chan_count[i] != '0));
    end
  end

  wsst_div #(
    .DVD_W (SUM_W),
    .DVS_W (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (cur_sum),
    .divisor  (cur_cnt),
    .done     (div_done),
    .quotient (div_quot)
  );

  // A zero count marks an empty channel, so a window end only has to clear
  // the counts; the first sample then overwrites sum, minimum and maximum.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      window_ticks <= WINDOW_RESET;
      tick_counter <= '0;
      scan         <= '0;
      out_valid    <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        chan_count[i] <= '0;
      end
    end else begin
      if (cfg_write) begin
        window_ticks <= cfg_data;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            if (q_cmd.kind == CMD_SAMPLE) begin
              if (cur_cnt != CW'(MAX_COUNT)) begin
                if (cur_cnt == '0) begin
                  running_sum[rd_idx] <= val_ext;
                  running_min[rd_idx] <= q_cmd.value;
                  running_max[rd_idx] <= q_cmd.value;
                end else begin
                  running_sum[rd_idx] <= cur_sum + val_ext;
                  if (q_cmd.value < cur_min) begin
                    running_min[rd_idx] <= q_cmd.value;
                  end
                  if (q_cmd.value > cur_max) begin
                    running_max[rd_idx] <= q_cmd.value;
                  end
                end
                chan_count[rd_idx] <= cur_cnt + 1'b1;
              end
            end else if (tick_next >= window_ticks) begin
              tick_counter <= '0;
              scan         <= '0;
              state        <= ST_SCAN;
            end else begin
              tick_counter <= tick_next;
            end
          end
        end
        ST_SCAN: begin
          if (cur_cnt != '0) begin
            state <= ST_DIV;
          end else if (scan_end) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
              chan_count[i] <= '0;
            end
            state <= ST_IDLE;
          end else begin
            scan <= CH_W'(scan + 1'b1);
          end
        end
        ST_DIV: begin
          if (emit) begin
            out_channel  <= scan[0];
            average      <= div_quot[VALUE_W-1:0];
            minimum      <= cur_min;
            maximum      <= cur_max;
            sample_count <= CNT_OUT_W'(cur_cnt);
            last         <= !more_after;
            if (scan_end) begin
              for (int i = 0; i < NUM_CHANNELS; i++) begin
                chan_count[i] <= '0;
              end
              state <= ST_IDLE;
            end else begin
              scan  <= CH_W'(scan + 1'b1);
              state <= ST_SCAN;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/windowed_sensor_statistics_core.sv
`default_nettype none

// Per-channel windowed statistics. Samples (operation 0) fold a valid reading
// into its channel's sum, minimum, maximum and count until that count reaches
// MAX_COUNT; ticks (operation 1) advance the window, and the tick that reaches
// window_ticks emits one record per channel with samples, in ascending channel
// order, with last set on the final record, and then clears the window. The
// input side takes one transfer per cycle while the queue is not full into a
// two-entry command queue; outside a window end the execution side retires a
// sample or an ordinary tick as it pops it, so samples and ticks sustain one
// item per cycle. A window end runs a serial divider that produces one
// quotient bit per cycle: an empty channel is skipped, and a channel with
// samples starts the divider and waits for its quotient and any output stall
// before its record is emitted. While that runs the queue fills and in_stall
// rises. Write window_ticks only while the block is idle; zero acts as one.
module windowed_sensor_statistics_core #(
  parameter int NUM_CHANNELS = 2,
  parameter int MAX_COUNT    = 1023
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_write,
  input  wire logic [wsst_pkg::TICK_W-1:0]           cfg_data,
  input  wire logic                                  in_valid,
  output      logic                                  in_stall,
  input  wire logic                                  operation,
  input  wire logic                                  channel,
  input  wire logic signed [wsst_pkg::VALUE_W-1:0]   value,
  input  wire logic                                  sample_valid,
  output      logic                                  out_valid,
  input  wire logic                                  out_stall,
  output      logic                                  out_channel,
  output      logic signed [wsst_pkg::VALUE_W-1:0]   average,
  output      logic signed [wsst_pkg::VALUE_W-1:0]   minimum,
  output      logic signed [wsst_pkg::VALUE_W-1:0]   maximum,
  output      logic [wsst_pkg::CNT_OUT_W-1:0]        sample_count,
  output      logic                                  last
);
  import wsst_pkg::*;

  cmd_t push_cmd;
  cmd_t pop_cmd;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  wsst_front #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .channel      (channel),
    .value        (value),
    .sample_valid (sample_valid),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (push_cmd)
  );

  wsst_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  wsst_back #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .MAX_COUNT    (MAX_COUNT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .q_empty      (q_empty),
    .q_cmd        (pop_cmd),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_channel  (out_channel),
    .average      (average),
    .minimum      (minimum),
    .maximum      (maximum),
    .sample_count (sample_count),
    .last         (last)
  );

endmodule

`default_nettype wire
